/* hdl/trajectory_smoothing_correction_macros.svh */
// Assertion macros for the trajectory smoothing correction checker.
// No dependencies; included by the checker file only.
`ifndef TRAJECTORY_SMOOTHING_CORRECTION_MACROS_SVH
`define TRAJECTORY_SMOOTHING_CORRECTION_MACROS_SVH

// cond at one edge implies expr at the next edge
`define TSC_ASSERT_NEXT(label, ck, rn, cond, expr) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (cond) |=> (expr)) \
        else $error("tsc check failed: next-cycle rule");

// cond implies expr at the same edge
`define TSC_ASSERT_SAME(label, ck, rn, cond, expr) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (cond) |-> (expr)) \
        else $error("tsc check failed: same-cycle rule");

`endif

/* hdl/tsc_pkg.sv */
// Shared types and constants for the trajectory smoothing correction block.
// No dependencies; used by the interfaces, the ring memory, divider and top level.
package tsc_pkg;

    localparam int HALF_W  = 6;
    localparam logic [HALF_W-1:0] HALF_RESET = 6'd30;
    localparam int DATA_W  = 32;
    localparam int PATH_W  = 48;
    localparam int ACC_W   = 55;
    localparam int MAG_W   = 48;
    localparam int QUO_W   = 49;
    localparam int DIFF_W  = 50;
    localparam int CNT_W   = 7;
    localparam int STEP_W  = 6;
    localparam int FS_W    = 8;
    localparam logic [FS_W-1:0] FS_MAX = 8'd255;
    localparam int AXES    = 3;
    localparam int AXIS_W  = 2;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

    typedef struct packed {
        logic [PATH_W-1:0] angle;
        logic [PATH_W-1:0] y;
        logic [PATH_W-1:0] x;
    } path_row_t;

endpackage

/* hdl/tsc_if.sv */
// Valid/ready stream interfaces for frame deltas and corrections.
// Depends on tsc_pkg for field widths.
interface tsc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [tsc_pkg::DATA_W-1:0] delta_x;
    logic signed [tsc_pkg::DATA_W-1:0] delta_y;
    logic signed [tsc_pkg::DATA_W-1:0] delta_angle;
    logic                              last_frame;

    modport source (output valid, delta_x, delta_y, delta_angle, last_frame, input ready);
    modport sink   (input valid, delta_x, delta_y, delta_angle, last_frame, output ready);
endinterface

interface tsc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tsc_pkg::DATA_W-1:0] corr_x;
    logic signed [tsc_pkg::DATA_W-1:0] corr_y;
    logic signed [tsc_pkg::DATA_W-1:0] corr_angle;
    logic                              final_result;

    modport source (output valid, corr_x, corr_y, corr_angle, final_result, input ready);
    modport sink   (input valid, corr_x, corr_y, corr_angle, final_result, output ready);
endinterface

/* hdl/tsc_ring_ram.sv */
// Trajectory ring: one row of x, y, angle path points per frame slot.
// Depends on tsc_pkg for the row type. One write and one registered read port.
module tsc_ring_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  tsc_pkg::path_row_t wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output tsc_pkg::path_row_t rd_data
);

    tsc_pkg::path_row_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/tsc_divider.sv */
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tsc_pkg. The quotient magnitude must fit in MAG_W bits.
module tsc_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tsc_pkg::ACC_W-1:0]  dividend,
    input  logic [tsc_pkg::CNT_W-1:0]         divisor,
    output logic                              done,
    output logic signed [tsc_pkg::QUO_W-1:0]  quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          neg_reg, neg_next;
    logic [tsc_pkg::CNT_W-1:0]     div_reg, div_next;
    logic [tsc_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [tsc_pkg::MAG_W-1:0]     q_reg, q_next;
    logic [tsc_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [tsc_pkg::ACC_W-1:0]     mag;
    logic [tsc_pkg::CNT_W:0]       rem_sh;
    logic                          fits;

    always_comb
    begin
        mag    = dividend[tsc_pkg::ACC_W-1] ? tsc_pkg::ACC_W'(~dividend + 1'b1)
                                            : tsc_pkg::ACC_W'(dividend);
        rem_sh = {rem_reg, q_reg[tsc_pkg::MAG_W-1]};
        fits   = (rem_sh >= {1'b0, div_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;

        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[tsc_pkg::ACC_W-1];
            div_next  = divisor;
            rem_next  = mag[tsc_pkg::ACC_W-1:tsc_pkg::MAG_W];
            q_next    = mag[tsc_pkg::MAG_W-1:0];
            step_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? tsc_pkg::CNT_W'(rem_sh - {1'b0, div_reg})
                             : rem_sh[tsc_pkg::CNT_W-1:0];
            q_next    = {q_reg[tsc_pkg::MAG_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == tsc_pkg::STEP_W'(tsc_pkg::MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? tsc_pkg::QUO_W'(-$signed({1'b0, q_reg}))
                              : tsc_pkg::QUO_W'($signed({1'b0, q_reg}));

endmodule

/* hdl/trajectory_smoothing_correction.sv */
// Trajectory smoothing correction: top level with the sequencer and path sums.
// Depends on tsc_pkg, tsc_if, tsc_ring_ram and tsc_divider.
//
// Use: one beat on the delta channel per video frame (x, y, angle deltas in
// Q16.16, last_frame on the final frame). The block keeps the running path,
// averages it over a window of +/- half_window frames and returns the mean
// minus the frame's own path on the result channel, half_window frames late.
// half_window is written through cfg_we/cfg_wdata and takes effect with the
// next sequence. A beat with last_frame set flushes all pending corrections,
// oldest first, final_result marking the newest, and restarts the sequence.
// Each correction reads one ring row per window frame, hi + 1 being the
// clipped window length (at most 2*half_window + 1), then runs three passes
// of the 48-step serial divider. A flush repeats that per correction.
// delta.ready is high only while the sequencer is idle. Results sit in an
// output register; a stalled receiver holds the sequencer only when the next
// correction is ready to be loaded. Reset clears the sequence and the output
// valid flag and sets half_window to 30; the ring needs no clearing.
module trajectory_smoothing_correction #(
    parameter int MAX_HALF_WINDOW = 63,
    parameter int RING_DEPTH      = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tsc_pkg::HALF_W-1:0]    cfg_wdata,
    tsc_in_if.sink                        delta,
    tsc_out_if.source                     result
);

    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int RING_HALF  = (RING_DEPTH - 1) / 2;
    localparam int HALF_CAP   = (MAX_HALF_WINDOW < RING_HALF) ? MAX_HALF_WINDOW : RING_HALF;
    localparam logic [tsc_pkg::HALF_W-1:0] HALF_CAP_V = tsc_pkg::HALF_W'(HALF_CAP);
    localparam logic [PTR_W:0]   DEPTH_V   = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PLAN     = 3'd1;
    localparam logic [2:0] ST_START    = 3'd2;
    localparam logic [2:0] ST_SUM      = 3'd3;
    localparam logic [2:0] ST_DIV_GO   = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT = 3'd5;
    localparam logic [2:0] ST_EMIT     = 3'd6;

    localparam int PW = tsc_pkg::PATH_W;
    localparam int DW = tsc_pkg::DATA_W;
    localparam int AX = tsc_pkg::AXES;

    function automatic logic signed [PW-1:0] sat_add48(
        input logic signed [PW-1:0] a,
        input logic signed [DW-1:0] d
    );
        logic [PW:0] s;
        s = {a[PW-1], a} + {{(PW + 1 - DW){d[DW-1]}}, d};
        if (s[PW] != s[PW-1])
        begin
            return s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        return s[PW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic [tsc_pkg::DIFF_W-1:0] v);
        logic [tsc_pkg::DIFF_W-DW:0] top;
        top = v[tsc_pkg::DIFF_W-1:DW-1];
        if ((top == '0) || (top == '1))
        begin
            return v[DW-1:0];
        end
        return v[tsc_pkg::DIFF_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    logic [2:0]                       state_reg, state_next;
    logic [tsc_pkg::HALF_W-1:0]       half_window_reg, half_window_next;
    logic [tsc_pkg::HALF_W-1:0]       seq_half_reg, seq_half_next;
    logic [tsc_pkg::FS_W-1:0]         fs_reg, fs_next;
    logic [PTR_W-1:0]                 wp_reg, wp_next;
    logic [PTR_W-1:0]                 newest_reg, newest_next;
    logic signed [PW-1:0]             run_reg [AX];
    logic signed [PW-1:0]             run_next [AX];
    logic                             last_reg, last_next;
    logic [tsc_pkg::HALF_W-1:0]       age_reg, age_next;
    logic [tsc_pkg::CNT_W-1:0]        hi_reg, hi_next;
    logic [tsc_pkg::CNT_W-1:0]        k_reg, k_next;
    logic                             issue_done_reg, issue_done_next;
    logic                             pend_reg, pend_next;
    logic [tsc_pkg::CNT_W-1:0]        pend_k_reg, pend_k_next;
    logic signed [tsc_pkg::ACC_W-1:0] acc_reg [AX];
    logic signed [tsc_pkg::ACC_W-1:0] acc_next [AX];
    logic signed [PW-1:0]             own_reg [AX];
    logic signed [PW-1:0]             own_next [AX];
    logic signed [DW-1:0]             corr_reg [AX];
    logic signed [DW-1:0]             corr_next [AX];
    logic [tsc_pkg::AXIS_W-1:0]       axis_reg, axis_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [DW-1:0]             out_corr_reg [AX];
    logic signed [DW-1:0]             out_corr_next [AX];
    logic                             out_final_reg, out_final_next;

    logic signed [DW-1:0]             delta_vec [AX];
    logic signed [PW-1:0]             run_sat [AX];
    logic signed [PW-1:0]             rd_vec [AX];
    logic                             accept;
    logic [tsc_pkg::HALF_W-1:0]       eff_half;
    logic [tsc_pkg::FS_W-1:0]         fs_m1;
    logic [tsc_pkg::CNT_W-1:0]        age_plus;
    logic [PTR_W-1:0]                 k_lo;
    logic [PTR_W-1:0]                 rd_slot;

    logic                             wr_en;
    tsc_pkg::path_row_t               wr_row;
    logic                             rd_en;
    tsc_pkg::path_row_t               rd_row;

    logic                             div_start;
    logic                             div_done;
    logic [tsc_pkg::CNT_W-1:0]        div_divisor;
    logic signed [tsc_pkg::QUO_W-1:0] div_quot;
    logic [tsc_pkg::DIFF_W-1:0]       diff;

    assign delta_vec[0] = delta.delta_x;
    assign delta_vec[1] = delta.delta_y;
    assign delta_vec[2] = delta.delta_angle;
    assign rd_vec[0]    = rd_row.x;
    assign rd_vec[1]    = rd_row.y;
    assign rd_vec[2]    = rd_row.angle;

    assign accept   = delta.valid && delta.ready;
    assign eff_half = (half_window_reg > HALF_CAP_V) ? HALF_CAP_V : half_window_reg;
    assign fs_m1    = fs_reg - 1'b1;
    assign age_plus = tsc_pkg::CNT_W'(age_reg) + tsc_pkg::CNT_W'(seq_half_reg);
    assign k_lo     = k_reg[PTR_W-1:0];
    assign rd_slot  = (newest_reg >= k_lo) ? (newest_reg - k_lo)
                                           : PTR_W'({1'b0, newest_reg} + DEPTH_V - {1'b0, k_lo});
    assign div_divisor = hi_reg + 1'b1;
    assign diff = {div_quot[tsc_pkg::QUO_W-1], div_quot}
                - {{(tsc_pkg::DIFF_W - PW){own_reg[axis_reg][PW-1]}}, own_reg[axis_reg]};

    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            run_sat[i] = sat_add48(run_reg[i], delta_vec[i]);
        end
        wr_row.x     = run_sat[0];
        wr_row.y     = run_sat[1];
        wr_row.angle = run_sat[2];
    end

    always_comb
    begin
        state_next       = state_reg;
        half_window_next = cfg_we ? cfg_wdata : half_window_reg;
        seq_half_next    = seq_half_reg;
        fs_next          = fs_reg;
        wp_next          = wp_reg;
        newest_next      = newest_reg;
        last_next        = last_reg;
        age_next         = age_reg;
        hi_next          = hi_reg;
        k_next           = k_reg;
        issue_done_next  = issue_done_reg;
        pend_next        = 1'b0;
        pend_k_next      = k_reg;
        axis_next        = axis_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_final_next   = out_final_reg;
        for (int i = 0; i < AX; i++)
        begin
            run_next[i]      = run_reg[i];
            acc_next[i]      = acc_reg[i];
            own_next[i]      = own_reg[i];
            corr_next[i]     = corr_reg[i];
            out_corr_next[i] = out_corr_reg[i];
        end
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (fs_reg == '0)
                    begin
                        seq_half_next = eff_half;
                    end
                    for (int i = 0; i < AX; i++)
                    begin
                        run_next[i] = run_sat[i];
                    end
                    wr_en       = 1'b1;
                    newest_next = wp_reg;
                    wp_next     = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
                    fs_next     = (fs_reg == tsc_pkg::FS_MAX) ? fs_reg : fs_reg + 1'b1;
                    last_next   = delta.last_frame;
                    state_next  = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                if (!last_reg)
                begin
                    if (fs_reg > tsc_pkg::FS_W'(seq_half_reg))
                    begin
                        age_next   = seq_half_reg;
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    age_next   = (fs_m1 < tsc_pkg::FS_W'(seq_half_reg))
                                 ? fs_m1[tsc_pkg::HALF_W-1:0] : seq_half_reg;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                hi_next = (tsc_pkg::FS_W'(age_plus) <= fs_m1) ? age_plus
                                                              : fs_m1[tsc_pkg::CNT_W-1:0];
                if ((fs_reg != tsc_pkg::FS_MAX) && (tsc_pkg::FS_W'(age_reg) == fs_m1))
                begin
                    // first frame of the sequence: correction is zero
                    for (int i = 0; i < AX; i++)
                    begin
                        corr_next[i] = '0;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    for (int i = 0; i < AX; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    k_next          = '0;
                    issue_done_next = 1'b0;
                    state_next      = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (!issue_done_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    if (k_reg == hi_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    for (int i = 0; i < AX; i++)
                    begin
                        acc_next[i] = acc_reg[i]
                            + {{(tsc_pkg::ACC_W - PW){rd_vec[i][PW-1]}}, rd_vec[i]};
                        if (pend_k_reg == tsc_pkg::CNT_W'(age_reg))
                        begin
                            own_next[i] = rd_vec[i];
                        end
                    end
                end
                if (issue_done_reg && !pend_reg)
                begin
                    axis_next  = tsc_pkg::AXIS_X;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    corr_next[axis_reg] = sat32(diff);
                    if (axis_reg == tsc_pkg::AXIS_LAST)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_final_next = last_reg && (age_reg == '0);
                    for (int i = 0; i < AX; i++)
                    begin
                        out_corr_next[i] = corr_reg[i];
                    end
                    if (last_reg && (age_reg != '0))
                    begin
                        age_next   = age_reg - 1'b1;
                        state_next = ST_START;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            for (int i = 0; i < AX; i++)
                            begin
                                run_next[i] = '0;
                            end
                            fs_next       = '0;
                            wp_next       = '0;
                            seq_half_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            half_window_reg <= tsc_pkg::HALF_RESET;
            seq_half_reg    <= '0;
            fs_reg          <= '0;
            wp_reg          <= '0;
            last_reg        <= 1'b0;
            age_reg         <= '0;
            issue_done_reg  <= 1'b0;
            pend_reg        <= 1'b0;
            axis_reg        <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < AX; i++)
            begin
                run_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            half_window_reg <= half_window_next;
            seq_half_reg    <= seq_half_next;
            fs_reg          <= fs_next;
            wp_reg          <= wp_next;
            last_reg        <= last_next;
            age_reg         <= age_next;
            issue_done_reg  <= issue_done_next;
            pend_reg        <= pend_next;
            axis_reg        <= axis_next;
            out_valid_reg   <= out_valid_next;
            for (int i = 0; i < AX; i++)
            begin
                run_reg[i] <= run_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg    <= newest_next;
        hi_reg        <= hi_next;
        k_reg         <= k_next;
        pend_k_reg    <= pend_k_next;
        out_final_reg <= out_final_next;
        for (int i = 0; i < AX; i++)
        begin
            acc_reg[i]      <= acc_next[i];
            own_reg[i]      <= own_next[i];
            corr_reg[i]     <= corr_next[i];
            out_corr_reg[i] <= out_corr_next[i];
        end
    end

    tsc_ring_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_slot),
        .rd_data (rd_row)
    );

    tsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[axis_reg]),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign delta.ready         = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.corr_x       = out_corr_reg[0];
    assign result.corr_y       = out_corr_reg[1];
    assign result.corr_angle   = out_corr_reg[2];
    assign result.final_result = out_final_reg;

endmodule

/* hdl/tsc_checker.sv */
// Port-level checker for the trajectory smoothing correction block, with its bind.
// Depends on trajectory_smoothing_correction_macros.svh and tsc_pkg.
`include "trajectory_smoothing_correction_macros.svh"

module tsc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [tsc_pkg::DATA_W-1:0] out_corr_x,
    input logic signed [tsc_pkg::DATA_W-1:0] out_corr_y,
    input logic signed [tsc_pkg::DATA_W-1:0] out_corr_angle,
    input logic                             out_final_result
);

    // an accepted beat keeps the block busy for at least the next cycle
    `TSC_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new result is only produced by the sequencer, never while idle
    `TSC_ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

    `TSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    `TSC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(out_corr_x) && $stable(out_corr_y) && $stable(out_corr_angle)
        && $stable(out_final_result))

endmodule

bind trajectory_smoothing_correction tsc_checker u_tsc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (delta.valid),
    .in_ready         (delta.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_corr_x       (result.corr_x),
    .out_corr_y       (result.corr_y),
    .out_corr_angle   (result.corr_angle),
    .out_final_result (result.final_result)
);
